// ===== rtl/poisson_blend_jacobi_solver_core_defines.svh =====
// Assertion macros shared by the Poisson blending solver RTL.
`ifndef POISSON_BLEND_JACOBI_SOLVER_CORE_DEFINES_SVH
`define POISSON_BLEND_JACOBI_SOLVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PBJS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pbjs assertion failed");
`define PBJS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbjs assertion failed");
`else
`define PBJS_ASSERT_IMP(label, ante, cons)
`define PBJS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/pbjs_pkg.sv =====
// Package with the types, codes and constants of the Poisson blending solver.
`timescale 1ns / 1ps
package pbjs_pkg;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int VAL_W  = 20;
	localparam int ACC_W  = 23;
	localparam int DIFF_W = 24;
	localparam int RES_W  = 40;
	localparam int SWP_W  = 17;
	localparam int TOT_W  = 42;
	localparam int CFG_W  = 20;
	localparam int BYTE_W = 8;
	localparam int NCH    = 3;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sd524287;
	localparam logic signed [VAL_W-1:0] VAL_MIN = -20'sd524288;
	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_RUN  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [2:0] CFG_WIDTH    = 3'd0;
	localparam logic [2:0] CFG_HEIGHT   = 3'd1;
	localparam logic [2:0] CFG_SWEEPS   = 3'd2;
	localparam logic [2:0] CFG_INTERVAL = 3'd3;
	localparam logic [2:0] CFG_EPS      = 3'd4;

	localparam logic [8:0]  WIDTH_RST    = 9'd256;
	localparam logic [8:0]  HEIGHT_RST   = 9'd256;
	localparam logic [15:0] SWEEPS_RST   = 16'd5000;
	localparam logic [15:0] INTERVAL_RST = 16'd1;
	localparam logic [19:0] EPS_RST      = 20'd0;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_READ,
		ST_REPLY,
		ST_CNT_RD,
		ST_CNT_EV,
		ST_LIM,
		ST_BLK,
		ST_SWP,
		ST_PX_ADDR,
		ST_PX_SELF,
		ST_PX_UP,
		ST_PX_LEFT,
		ST_PX_RIGHT,
		ST_PX_DOWN,
		ST_PX_FIN,
		ST_PEND,
		ST_CMP
	} state_t;

	typedef enum logic [1:0] {
		PASS_UPDATE,
		PASS_CHECK,
		PASS_FINAL
	} pass_t;
endpackage

// ===== rtl/poisson_blend_jacobi_solver_core.sv =====
// Top level of the Poisson blending solver: pixel memory, sequencer and shared datapath.
`timescale 1ns / 1ps
`include "poisson_blend_jacobi_solver_core_defines.svh"
// The input channel (in_valid, in_stall) carries one request a beat: load a pixel, run a
// solve or read a pixel back. The output channel (out_valid, out_stall) returns exactly one
// result beat for every request, in order, from an output register.
// Configuration registers are written through cfg_we, cfg_index and cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it. A load or unknown
// request passes through ST_REPLY to the output register, a read through ST_READ first.
// A solve walks the pixel memory through one read port: a counting pass over every pixel,
// then a walk over all pixels for each sweep and each residual pass, with the four
// neighbours of each masked interior pixel fetched one after another.
// The block holds in_stall high while it works on a request and while a finished result
// waits in the state before the output register. It accepts a new request as soon as the
// result has moved into the output register, even while the receiver stalls it.
// Reset restores the configuration defaults and clears the result state; the pixel
// memory is not cleared and must be loaded before it is used.
module poisson_blend_jacobi_solver_core #(
	parameter int MAX_WIDTH  = pbjs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pbjs_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = pbjs_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [15:0]        pixel_index,
	input  logic               mask_bit,
	input  logic signed [19:0] target_red,
	input  logic signed [19:0] target_green,
	input  logic signed [19:0] target_blue,
	input  logic signed [19:0] guide_red,
	input  logic signed [19:0] guide_green,
	input  logic signed [19:0] guide_blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         pixel_red,
	output logic [7:0]         pixel_green,
	output logic [7:0]         pixel_blue,
	output logic [39:0]        residual_red,
	output logic [39:0]        residual_green,
	output logic [39:0]        residual_blue,
	output logic [16:0]        sweeps_done,
	output logic               converged_flag,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W = AW + 1;
	localparam int LIM_W = CNT_W + 22;
	localparam int VW    = pbjs_pkg::VAL_W;
	localparam int NCH   = pbjs_pkg::NCH;

	logic                 mask_mem [DEPTH];
	logic [NCH*VW-1:0]    tgt_mem  [DEPTH];
	logic [NCH*VW-1:0]    gd_mem   [DEPTH];
	logic                 mask_rd_q;
	logic [NCH*VW-1:0]    tgt_rd_q;
	logic [NCH*VW-1:0]    gd_rd_q;

	logic [8:0]           width_q;
	logic [8:0]           height_q;
	logic [15:0]          max_sweeps_q;
	logic [15:0]          interval_q;
	logic [19:0]          eps_q;

	pbjs_pkg::state_t     state_q, state_d;
	pbjs_pkg::pass_t      pass_q;
	logic [HW-1:0]        row_q;
	logic [WW-1:0]        col_q;
	logic [AW-1:0]        id_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LIM_W-1:0]     lim_q;
	logic [pbjs_pkg::SWP_W-1:0] sweep_q;
	logic [15:0]          sub_q;
	logic                 stop_q;
	logic                 hit_q;
	logic signed [pbjs_pkg::ACC_W-1:0] acc_q  [NCH];
	logic signed [VW-1:0]              self_q [NCH];
	logic [pbjs_pkg::RES_W-1:0]        res_q  [NCH];
	logic [7:0]                        pix_q  [NCH];

	logic                 out_valid_q;
	logic [7:0]           out_pix_q [NCH];
	logic [pbjs_pkg::RES_W-1:0] out_res_q [NCH];
	logic [pbjs_pkg::SWP_W-1:0] out_sweeps_q;
	logic                 out_conv_q;

	logic [WW-1:0]        w_eff, w_m1;
	logic [HW-1:0]        h_eff, h_m1;
	logic [15:0]          intv_eff;
	logic [31:0]          idx32;
	logic                 in_hit;
	logic [AW-1:0]        in_addr;
	logic [AW-1:0]        raddr;
	logic                 last_px;
	logic                 inner_pos;
	logic                 accept;
	logic                 out_free;
	logic                 load_we;
	logic                 tgt_we;
	logic [AW-1:0]        tgt_waddr;
	logic [NCH*VW-1:0]    tgt_wdata;
	logic [NCH*VW-1:0]    upd_word;
	logic [NCH*VW-1:0]    load_tgt;
	logic [NCH*VW-1:0]    load_gd;
	logic signed [VW-1:0] tv [NCH];
	logic [7:0]           byte_v [NCH];
	logic [pbjs_pkg::RES_W-1:0] res_next [NCH];
	logic [pbjs_pkg::TOT_W-1:0] tot;
	logic [21:0]          eps3;

	always_comb begin
		if (width_q == 9'd0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == 9'd0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign w_m1      = w_eff - WW'(1);
	assign h_m1      = h_eff - HW'(1);
	assign intv_eff  = (interval_q == 16'd0) ? 16'd1 : interval_q;
	assign idx32     = 32'(pixel_index);
	assign in_hit    = idx32 < 32'(DEPTH);
	assign in_addr   = AW'(idx32);
	assign last_px   = (row_q == h_m1) && (col_q == w_m1);
	assign inner_pos = (row_q != '0) && (row_q != h_m1) && (col_q != '0) && (col_q != w_m1);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_we   = (state_q == pbjs_pkg::ST_IDLE) && in_valid &&
		(req_type == pbjs_pkg::REQ_LOAD) && in_hit;
	assign load_tgt  = {target_blue, target_green, target_red};
	assign load_gd   = {guide_blue, guide_green, guide_red};
	assign eps3      = 22'({eps_q, 1'b0}) + 22'(eps_q);
	assign tot       = pbjs_pkg::TOT_W'(res_q[0]) + pbjs_pkg::TOT_W'(res_q[1]) +
		pbjs_pkg::TOT_W'(res_q[2]);

	always_comb begin
		logic signed [pbjs_pkg::ACC_W-1:0]  q;
		logic signed [pbjs_pkg::DIFF_W-1:0] d;
		logic [pbjs_pkg::DIFF_W-1:0]        ad;
		logic [pbjs_pkg::RES_W:0]           rs;
		logic [VW-1:0]                      sh;
		upd_word = '0;
		for (int ch = 0; ch < NCH; ch++) begin
			tv[ch] = $signed(tgt_rd_q[ch*VW +: VW]);
			q = acc_q[ch] >>> 2;
			if (q > pbjs_pkg::ACC_W'(pbjs_pkg::VAL_MAX)) begin
				upd_word[ch*VW +: VW] = pbjs_pkg::VAL_MAX;
			end else if (q < pbjs_pkg::ACC_W'(pbjs_pkg::VAL_MIN)) begin
				upd_word[ch*VW +: VW] = pbjs_pkg::VAL_MIN;
			end else begin
				upd_word[ch*VW +: VW] = q[VW-1:0];
			end
			d = pbjs_pkg::DIFF_W'(acc_q[ch]) - (pbjs_pkg::DIFF_W'(self_q[ch]) <<< 2);
			ad = (d < 0) ? pbjs_pkg::DIFF_W'(-d) : pbjs_pkg::DIFF_W'(d);
			rs = {1'b0, res_q[ch]} + (pbjs_pkg::RES_W + 1)'(ad);
			res_next[ch] = rs[pbjs_pkg::RES_W] ? '1 : rs[pbjs_pkg::RES_W-1:0];
			sh = VW'(tv[ch] >>> FRAC_BITS);
			if (tv[ch] < 0) begin
				byte_v[ch] = '0;
			end else if (sh > VW'(pbjs_pkg::BYTE_MAX)) begin
				byte_v[ch] = pbjs_pkg::BYTE_MAX;
			end else begin
				byte_v[ch] = sh[7:0];
			end
		end
	end

	always_comb begin
		case (state_q)
			pbjs_pkg::ST_IDLE:     raddr = in_addr;
			pbjs_pkg::ST_PX_SELF:  raddr = id_q - AW'(w_eff);
			pbjs_pkg::ST_PX_UP:    raddr = id_q - AW'(1);
			pbjs_pkg::ST_PX_LEFT:  raddr = id_q + AW'(1);
			pbjs_pkg::ST_PX_RIGHT: raddr = id_q + AW'(w_eff);
			default:               raddr = id_q;
		endcase
		tgt_we    = load_we;
		tgt_waddr = in_addr;
		tgt_wdata = load_tgt;
		if (state_q == pbjs_pkg::ST_PX_FIN && pass_q == pbjs_pkg::PASS_UPDATE) begin
			tgt_we    = 1'b1;
			tgt_waddr = id_q;
			tgt_wdata = upd_word;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			mask_mem[in_addr] <= mask_bit;
			gd_mem[in_addr]   <= load_gd;
		end
		if (tgt_we) begin
			tgt_mem[tgt_waddr] <= tgt_wdata;
		end
		mask_rd_q <= mask_mem[raddr];
		tgt_rd_q  <= tgt_mem[raddr];
		gd_rd_q   <= gd_mem[raddr];
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != pbjs_pkg::ST_IDLE);
		case (state_q)
			pbjs_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (req_type)
						pbjs_pkg::REQ_RUN:  state_d = pbjs_pkg::ST_CNT_RD;
						pbjs_pkg::REQ_READ: state_d = pbjs_pkg::ST_READ;
						default:            state_d = pbjs_pkg::ST_REPLY;
					endcase
				end
			end
			pbjs_pkg::ST_READ:   state_d = pbjs_pkg::ST_REPLY;
			pbjs_pkg::ST_REPLY:  if (out_free) state_d = pbjs_pkg::ST_IDLE;
			pbjs_pkg::ST_CNT_RD: state_d = pbjs_pkg::ST_CNT_EV;
			pbjs_pkg::ST_CNT_EV: state_d = last_px ? pbjs_pkg::ST_LIM : pbjs_pkg::ST_CNT_RD;
			pbjs_pkg::ST_LIM:    state_d = pbjs_pkg::ST_BLK;
			pbjs_pkg::ST_BLK: begin
				if (sweep_q < pbjs_pkg::SWP_W'(max_sweeps_q) && !stop_q) begin
					state_d = pbjs_pkg::ST_SWP;
				end else begin
					state_d = pbjs_pkg::ST_PX_ADDR;
				end
			end
			pbjs_pkg::ST_SWP: begin
				if (sub_q < intv_eff) begin
					if (cnt_q != '0) state_d = pbjs_pkg::ST_PX_ADDR;
				end else if (eps_q != '0) begin
					state_d = pbjs_pkg::ST_PX_ADDR;
				end else begin
					state_d = pbjs_pkg::ST_BLK;
				end
			end
			pbjs_pkg::ST_PX_ADDR: state_d = pbjs_pkg::ST_PX_SELF;
			pbjs_pkg::ST_PX_SELF: begin
				if (mask_rd_q && inner_pos) begin
					state_d = pbjs_pkg::ST_PX_UP;
				end else begin
					state_d = last_px ? pbjs_pkg::ST_PEND : pbjs_pkg::ST_PX_ADDR;
				end
			end
			pbjs_pkg::ST_PX_UP:    state_d = pbjs_pkg::ST_PX_LEFT;
			pbjs_pkg::ST_PX_LEFT:  state_d = pbjs_pkg::ST_PX_RIGHT;
			pbjs_pkg::ST_PX_RIGHT: state_d = pbjs_pkg::ST_PX_DOWN;
			pbjs_pkg::ST_PX_DOWN:  state_d = pbjs_pkg::ST_PX_FIN;
			pbjs_pkg::ST_PX_FIN:   state_d = last_px ? pbjs_pkg::ST_PEND : pbjs_pkg::ST_PX_ADDR;
			pbjs_pkg::ST_PEND: begin
				case (pass_q)
					pbjs_pkg::PASS_UPDATE: state_d = pbjs_pkg::ST_SWP;
					pbjs_pkg::PASS_CHECK:  state_d = pbjs_pkg::ST_CMP;
					default:               state_d = pbjs_pkg::ST_REPLY;
				endcase
			end
			pbjs_pkg::ST_CMP: state_d = pbjs_pkg::ST_BLK;
			default:          state_d = pbjs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbjs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= pbjs_pkg::WIDTH_RST;
			height_q     <= pbjs_pkg::HEIGHT_RST;
			max_sweeps_q <= pbjs_pkg::SWEEPS_RST;
			interval_q   <= pbjs_pkg::INTERVAL_RST;
			eps_q        <= pbjs_pkg::EPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbjs_pkg::CFG_WIDTH:    width_q      <= cfg_data[8:0];
				pbjs_pkg::CFG_HEIGHT:   height_q     <= cfg_data[8:0];
				pbjs_pkg::CFG_SWEEPS:   max_sweeps_q <= cfg_data[15:0];
				pbjs_pkg::CFG_INTERVAL: interval_q   <= cfg_data[15:0];
				pbjs_pkg::CFG_EPS:      eps_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q      <= pbjs_pkg::PASS_UPDATE;
			row_q       <= '0;
			col_q       <= '0;
			id_q        <= '0;
			cnt_q       <= '0;
			sweep_q     <= '0;
			sub_q       <= '0;
			stop_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int ch = 0; ch < NCH; ch++) begin
				res_q[ch] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pbjs_pkg::ST_IDLE: begin
					if (accept) begin
						hit_q <= in_hit;
						row_q <= '0;
						col_q <= '0;
						id_q  <= '0;
						cnt_q <= '0;
						for (int ch = 0; ch < NCH; ch++) begin
							pix_q[ch] <= '0;
						end
					end
				end
				pbjs_pkg::ST_READ: begin
					if (hit_q) begin
						for (int ch = 0; ch < NCH; ch++) begin
							pix_q[ch] <= byte_v[ch];
						end
					end
				end
				pbjs_pkg::ST_REPLY: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sweeps_q <= sweep_q;
						out_conv_q   <= stop_q;
						for (int ch = 0; ch < NCH; ch++) begin
							out_pix_q[ch] <= pix_q[ch];
							out_res_q[ch] <= res_q[ch];
						end
					end
				end
				pbjs_pkg::ST_CNT_EV: begin
					if (mask_rd_q && inner_pos) cnt_q <= cnt_q + CNT_W'(1);
					if (col_q == w_m1) begin
						col_q <= '0;
						row_q <= row_q + HW'(1);
					end else begin
						col_q <= col_q + WW'(1);
					end
					id_q <= id_q + AW'(1);
				end
				pbjs_pkg::ST_LIM: begin
					lim_q   <= LIM_W'(eps3) * LIM_W'(cnt_q);
					sweep_q <= '0;
					stop_q  <= 1'b0;
				end
				pbjs_pkg::ST_BLK: begin
					sub_q <= '0;
					if (!(sweep_q < pbjs_pkg::SWP_W'(max_sweeps_q) && !stop_q)) begin
						pass_q <= pbjs_pkg::PASS_FINAL;
						row_q  <= '0;
						col_q  <= '0;
						id_q   <= '0;
						for (int ch = 0; ch < NCH; ch++) begin
							res_q[ch] <= '0;
						end
					end
				end
				pbjs_pkg::ST_SWP: begin
					row_q <= '0;
					col_q <= '0;
					id_q  <= '0;
					if (sub_q < intv_eff) begin
						pass_q <= pbjs_pkg::PASS_UPDATE;
						if (cnt_q == '0) begin
							sweep_q <= sweep_q + pbjs_pkg::SWP_W'(1);
							sub_q   <= sub_q + 16'd1;
						end
					end else begin
						pass_q <= pbjs_pkg::PASS_CHECK;
						for (int ch = 0; ch < NCH; ch++) begin
							res_q[ch] <= '0;
						end
					end
				end
				pbjs_pkg::ST_PX_SELF: begin
					for (int ch = 0; ch < NCH; ch++) begin
						acc_q[ch]  <= pbjs_pkg::ACC_W'($signed(gd_rd_q[ch*VW +: VW]));
						self_q[ch] <= tv[ch];
					end
					if (!(mask_rd_q && inner_pos)) begin
						if (col_q == w_m1) begin
							col_q <= '0;
							row_q <= row_q + HW'(1);
						end else begin
							col_q <= col_q + WW'(1);
						end
						id_q <= id_q + AW'(1);
					end
				end
				pbjs_pkg::ST_PX_UP, pbjs_pkg::ST_PX_LEFT,
				pbjs_pkg::ST_PX_RIGHT, pbjs_pkg::ST_PX_DOWN: begin
					for (int ch = 0; ch < NCH; ch++) begin
						acc_q[ch] <= acc_q[ch] + pbjs_pkg::ACC_W'(tv[ch]);
					end
				end
				pbjs_pkg::ST_PX_FIN: begin
					if (pass_q != pbjs_pkg::PASS_UPDATE) begin
						for (int ch = 0; ch < NCH; ch++) begin
							res_q[ch] <= res_next[ch];
						end
					end
					if (col_q == w_m1) begin
						col_q <= '0;
						row_q <= row_q + HW'(1);
					end else begin
						col_q <= col_q + WW'(1);
					end
					id_q <= id_q + AW'(1);
				end
				pbjs_pkg::ST_PEND: begin
					if (pass_q == pbjs_pkg::PASS_UPDATE) begin
						sweep_q <= sweep_q + pbjs_pkg::SWP_W'(1);
						sub_q   <= sub_q + 16'd1;
					end
				end
				pbjs_pkg::ST_CMP: begin
					if (cnt_q != '0 && tot < pbjs_pkg::TOT_W'(lim_q)) stop_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_red      = out_pix_q[0];
	assign pixel_green    = out_pix_q[1];
	assign pixel_blue     = out_pix_q[2];
	assign residual_red   = out_res_q[0];
	assign residual_green = out_res_q[1];
	assign residual_blue  = out_res_q[2];
	assign sweeps_done    = out_sweeps_q;
	assign converged_flag = out_conv_q;

	`PBJS_ASSERT_IMP(a_out_from_reply, $rose(out_valid_q), $past(state_q == pbjs_pkg::ST_REPLY))
	`PBJS_ASSERT_IMP(a_stop_needs_pixels, state_q == pbjs_pkg::ST_BLK && stop_q, cnt_q != '0)
	`PBJS_ASSERT_IMP(a_sub_bounded, state_q == pbjs_pkg::ST_SWP, sub_q <= intv_eff)
	`PBJS_ASSERT_NXT(a_update_in_solve, state_q == pbjs_pkg::ST_PX_FIN, state_q == pbjs_pkg::ST_PEND || state_q == pbjs_pkg::ST_PX_ADDR)
endmodule
